// ===== design/lps_pkg.sv =====
// lps_pkg: shared types, scene rom and constants for the led pattern sequencer
package lps_pkg;

    localparam int ROM_SCENES = 5;
    localparam int SCENE_W    = 3;
    localparam int PASS_W     = 5;
    localparam int ELAPSED_W  = 12;
    localparam int LIFE_W     = 11;
    localparam int PRI_W      = 3;
    localparam int PRIOS_W    = PRI_W * ROM_SCENES;
    localparam logic [PRIOS_W-1:0] PRIOS_RESET = 15'd4674;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_DIRECT = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [SCENE_W-1:0] scene_id;
        logic               led_select;
        logic               led_level;
    } t_in_item;

    typedef struct packed {
        logic                  red_on;
        logic                  blue_on;
        logic [SCENE_W-1:0]    playing_scene;
        logic [ROM_SCENES-1:0] running_mask;
    } t_out_item;

    typedef struct packed {
        logic              red;
        logic              blue;
        logic [LIFE_W-1:0] life_ms;
    } t_action;

    // number of passes of each scene
    function automatic logic [PASS_W-1:0] scene_passes(input logic [SCENE_W-1:0] s);
        logic [PASS_W-1:0] p;
        case (s)
            3'd0:    p = 5'd1;
            3'd1:    p = 5'd30;
            3'd2:    p = 5'd10;
            3'd3:    p = 5'd10;
            3'd4:    p = 5'd20;
            default: p = 5'd1;
        endcase
        return p;
    endfunction

    // actions per pass
    function automatic logic [1:0] scene_count(input logic [SCENE_W-1:0] s);
        return (s == 3'd0) ? 2'd1 : 2'd2;
    endfunction

    function automatic t_action scene_action(input logic [SCENE_W-1:0] s, input logic idx);
        t_action a;
        case ({s, idx})
            {3'd0, 1'b0}: a = '{red: 1'b1, blue: 1'b0, life_ms: 11'd2000};
            {3'd0, 1'b1}: a = '{red: 1'b0, blue: 1'b0, life_ms: 11'd2000};
            {3'd1, 1'b0}: a = '{red: 1'b0, blue: 1'b1, life_ms: 11'd1000};
            {3'd1, 1'b1}: a = '{red: 1'b0, blue: 1'b0, life_ms: 11'd1000};
            {3'd2, 1'b0}: a = '{red: 1'b0, blue: 1'b0, life_ms: 11'd500};
            {3'd2, 1'b1}: a = '{red: 1'b1, blue: 1'b0, life_ms: 11'd500};
            {3'd3, 1'b0}: a = '{red: 1'b1, blue: 1'b0, life_ms: 11'd100};
            {3'd3, 1'b1}: a = '{red: 1'b0, blue: 1'b0, life_ms: 11'd100};
            {3'd4, 1'b0}: a = '{red: 1'b0, blue: 1'b1, life_ms: 11'd500};
            {3'd4, 1'b1}: a = '{red: 1'b1, blue: 1'b0, life_ms: 11'd500};
            default:      a = '{red: 1'b0, blue: 1'b0, life_ms: 11'd0};
        endcase
        return a;
    endfunction

endpackage

// ===== design/lps_pick.sv =====
// lps_pick: priority winner among running scenes
module lps_pick (
    input  logic [lps_pkg::ROM_SCENES-1:0] i_running,
    input  logic [lps_pkg::PRIOS_W-1:0]    i_priorities,
    output logic                           o_found,
    output logic [lps_pkg::SCENE_W-1:0]    o_winner
);
    import lps_pkg::*;

    logic [PRI_W:0] best_pri;
    logic [PRI_W:0] pri;

    // strict less-than keeps the lower index on a tie
    always_comb begin
        best_pri = 4'd8;
        o_found  = 1'b0;
        o_winner = '0;
        for (int i = 0; i < ROM_SCENES; i++) begin
            pri = {1'b0, i_priorities[i*PRI_W +: PRI_W]};
            if (i_running[i] && (pri < best_pri)) begin
                best_pri = pri;
                o_found  = 1'b1;
                o_winner = SCENE_W'(i);
            end
        end
    end

endmodule

// ===== design/lps_core.sv =====
// lps_core: scene state registers and the single-pass update for one item
module lps_core #(
    parameter int NUM_SCENES     = 5,
    parameter int TICK_PERIOD_MS = 50
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  lps_pkg::t_in_item           i_item,
    input  logic [lps_pkg::PRIOS_W-1:0] i_priorities,
    output lps_pkg::t_out_item          o_next
);
    import lps_pkg::*;

    localparam int SCENE_NONE_I = (NUM_SCENES < ROM_SCENES) ? NUM_SCENES : ROM_SCENES;
    localparam logic [SCENE_W-1:0]   SCENE_NONE = SCENE_W'(SCENE_NONE_I);
    localparam logic [ELAPSED_W-1:0] TICK_MS    = ELAPSED_W'(TICK_PERIOD_MS);

    logic [ROM_SCENES-1:0] r_running, n_running;
    logic [PASS_W-1:0]     r_pass    [ROM_SCENES];
    logic [PASS_W-1:0]     n_pass    [ROM_SCENES];
    logic                  r_idx     [ROM_SCENES];
    logic                  n_idx     [ROM_SCENES];
    logic [ELAPSED_W-1:0]  r_elapsed [ROM_SCENES];
    logic [ELAPSED_W-1:0]  n_elapsed [ROM_SCENES];
    logic [SCENE_W-1:0]    r_active, n_active;
    logic                  r_red, n_red;
    logic                  r_blue, n_blue;

    logic [ROM_SCENES-1:0] pick_run;
    logic                  win_found;
    logic [SCENE_W-1:0]    win_idx;
    logic [SCENE_W-1:0]    w;
    logic                  w_ok;
    logic [SCENE_W-1:0]    a;
    logic                  a_ok;
    logic [SCENE_W-1:0]    id;
    logic                  id_ok;
    logic [ELAPSED_W-1:0]  e;
    t_action               act;
    logic [1:0]            idx_inc;
    logic [PASS_W-1:0]     pass_inc;

    assign a     = r_active;
    assign a_ok  = (r_active < SCENE_NONE);
    assign id    = i_item.scene_id;
    assign id_ok = (id < SCENE_NONE);

    // running set that the winner is picked from after this item
    always_comb begin
        pick_run = r_running;
        case (i_item.opcode)
            OP_TICK:   if (a_ok) pick_run[a] = 1'b0;
            OP_START:  if (id_ok) pick_run[id] = 1'b1;
            OP_CANCEL: if (id_ok) pick_run[id] = 1'b0;
            default:   pick_run = r_running;
        endcase
    end

    lps_pick u_pick (
        .i_running    (pick_run),
        .i_priorities (i_priorities),
        .o_found      (win_found),
        .o_winner     (win_idx)
    );

    assign w    = win_found ? win_idx : SCENE_NONE;
    assign w_ok = win_found;

    always_comb begin
        n_running = r_running;
        n_pass    = r_pass;
        n_idx     = r_idx;
        n_elapsed = r_elapsed;
        n_active  = r_active;
        n_red     = r_red;
        n_blue    = r_blue;
        e         = r_elapsed[a] + TICK_MS;
        act       = scene_action(a, r_idx[a]);
        idx_inc   = {1'b0, r_idx[a]} + 2'd1;
        pass_inc  = r_pass[a] + 5'd1;

        unique case (i_item.opcode)
            OP_TICK: begin
                if (a_ok && r_running[a]) begin
                    n_elapsed[a] = e;
                    if (e < {1'b0, act.life_ms}) begin
                        n_red  = act.red;
                        n_blue = act.blue;
                    end else if (idx_inc >= scene_count(a)) begin
                        // end of a pass
                        n_idx[a]  = 1'b0;
                        n_pass[a] = pass_inc;
                        if (pass_inc >= scene_passes(a)) begin
                            // scene finished, hand over without restarting
                            n_running[a] = 1'b0;
                            n_red        = 1'b0;
                            n_blue       = 1'b0;
                            n_active     = w;
                            if (w_ok) n_elapsed[w] = '0;
                        end else begin
                            n_elapsed[a] = '0;
                        end
                    end else begin
                        n_idx[a]     = idx_inc[0];
                        n_elapsed[a] = '0;
                    end
                end
            end
            OP_START: begin
                if (id_ok && !r_running[id]) begin
                    n_running[id] = 1'b1;
                    n_pass[id]    = '0;
                    n_idx[id]     = 1'b0;
                    n_elapsed[id] = '0;
                    if (w != r_active) begin
                        if (a_ok) n_running[a] = 1'b0;
                        n_active = w;
                    end
                    if (w_ok) begin
                        n_pass[w]    = '0;
                        n_idx[w]     = 1'b0;
                        n_elapsed[w] = '0;
                    end
                end
            end
            OP_CANCEL: begin
                if (id_ok) begin
                    n_running[id] = 1'b0;
                    if (r_active == id) begin
                        n_red    = 1'b0;
                        n_blue   = 1'b0;
                        n_active = w;
                        if (w_ok) begin
                            n_pass[w]    = '0;
                            n_idx[w]     = 1'b0;
                            n_elapsed[w] = '0;
                        end
                    end
                end
            end
            OP_DIRECT: begin
                if (i_item.led_select) n_blue = i_item.led_level;
                else                   n_red  = i_item.led_level;
            end
            default: n_active = r_active;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_active  <= SCENE_NONE;
            r_red     <= 1'b0;
            r_blue    <= 1'b0;
            for (int i = 0; i < ROM_SCENES; i++) begin
                r_pass[i]    <= '0;
                r_idx[i]     <= 1'b0;
                r_elapsed[i] <= '0;
            end
        end else if (i_fire) begin
            r_running <= n_running;
            r_active  <= n_active;
            r_red     <= n_red;
            r_blue    <= n_blue;
            r_pass    <= n_pass;
            r_idx     <= n_idx;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_next.red_on        = n_red;
    assign o_next.blue_on       = n_blue;
    assign o_next.playing_scene = n_active;
    assign o_next.running_mask  = n_running;

endmodule

// ===== design/led_pattern_sequencer_with_priority.sv =====
// led_pattern_sequencer_with_priority: top level, input and result registers
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  in       | in        | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out      | out       | o_out_valid / i_out_stall| o_out_item (t_out_item)
//  cfg      | in        | i_cfg_wr_en              | i_cfg_wr_data (priorities)
//
//  one item per cycle sustained while out does not stall; a result is presented after the
//  transfer in via the input register, then the state update straight into the result register
//  synchronous active-low reset clears all scene state, leds off, no scene playing
//  a stall on out holds the result; the input register still takes one more item,
//  after which in stalls until out frees up
module led_pattern_sequencer_with_priority #(
    parameter int NUM_SCENES     = 5,
    parameter int TICK_PERIOD_MS = 50
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lps_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lps_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_wr_en,
    input  logic [lps_pkg::PRIOS_W-1:0] i_cfg_wr_data
);
    import lps_pkg::*;

    logic               r_in_valid;
    t_in_item           r_in_item;
    logic               r_out_valid;
    t_out_item          r_out_item;
    logic [PRIOS_W-1:0] r_priorities;

    logic               advance;
    logic               fire;
    logic               in_xfer;
    t_out_item          next_result;

    // the held item moves on when the result register is empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // priority register, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priorities <= PRIOS_RESET;
        end else if (i_cfg_wr_en) begin
            r_priorities <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_item;
        end
    end

    // scene state and the whole update for one item
    lps_core #(
        .NUM_SCENES     (NUM_SCENES),
        .TICK_PERIOD_MS (TICK_PERIOD_MS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in_item),
        .i_priorities (r_priorities),
        .o_next       (next_result)
    );

    // result register, loaded in the same edge that commits the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= next_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== bench/led_pattern_sequencer_with_priority_tb.sv =====
// testbench for the led pattern sequencer: directed and random command streams checked per transfer
`timescale 1ns / 1ps

module led_pattern_sequencer_with_priority_tb;
    import lps_pkg::*;

    localparam int                 N_SCENES    = 5;
    localparam int                 TICK_MS     = 50;
    localparam logic [SCENE_W-1:0] NO_SCENE    = 3'd5;
    localparam int                 PHASE_ITEMS = 50;
    localparam int                 N_PHASES    = 7;
    localparam int                 HOLD_CYCLES = 120;
    localparam int                 QUIET_LIMIT = 2000;
    localparam int                 MAX_PRINTS  = 200;

    // block ports, all inputs driven to known values from time zero
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item     = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    t_out_item          o_out_item;
    logic               i_cfg_wr_en   = 1'b0;
    logic [PRIOS_W-1:0] i_cfg_wr_data = '0;

    // commands waiting to be sent, and led states still owed by the block
    t_in_item  cmd_q[$];
    t_out_item pending_leds[$];

    // handshake bookkeeping shared between the clocked processes
    bit in_xfer;
    bit out_xfer;
    int send_gap      = 0;
    int send_gap_max  = 0;
    int take_wait     = 0;
    int take_wait_max = 0;
    bit pressure_go   = 1'b0;
    int hold_cnt      = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;
    logic hold_active;

    // behavioural copy of the sequencer state
    logic [PRIOS_W-1:0]   prio_word;
    logic                 sc_running [N_SCENES];
    logic [PASS_W-1:0]    sc_pass    [N_SCENES];
    logic                 sc_step    [N_SCENES];
    logic [ELAPSED_W-1:0] sc_elapsed [N_SCENES];
    logic [SCENE_W-1:0]   now_playing;
    logic                 red_lit;
    logic                 blue_lit;

    led_pattern_sequencer_with_priority #(
        .NUM_SCENES     (N_SCENES),
        .TICK_PERIOD_MS (TICK_MS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // sequencer behaviour
    // ------------------------------------------------------------------

    // running scene with the smallest priority number, lower index on a tie
    function automatic logic [SCENE_W-1:0] best_scene();
        logic [SCENE_W-1:0] best;
        logic [PRI_W:0]     best_pri;
        best     = NO_SCENE;
        best_pri = 4'd8;
        for (int s = 0; s < N_SCENES; s++) begin
            if (sc_running[s] && {1'b0, prio_word[PRI_W*s +: PRI_W]} < best_pri) begin
                best_pri = {1'b0, prio_word[PRI_W*s +: PRI_W]};
                best     = SCENE_W'(s);
            end
        end
        return best;
    endfunction

    function automatic void rewind(int s);
        sc_pass[s]    = '0;
        sc_step[s]    = 1'b0;
        sc_elapsed[s] = '0;
    endfunction

    function automatic void tick_active();
        logic [ELAPSED_W-1:0] life;
        logic [PASS_W-1:0]    passes;
        logic [1:0]           n_steps;
        logic [1:0]           nxt;
        logic                 red_a;
        logic                 blue_a;
        int                   a;
        // nothing to advance when idle
        if (now_playing >= NO_SCENE) return;
        a = now_playing;
        if (!sc_running[a]) return;
        n_steps = 2'd2;
        case (a)
            0: begin
                passes = 5'd1;  n_steps = 2'd1; life = 12'd2000;
                red_a  = !sc_step[a]; blue_a = 1'b0;
            end
            1: begin
                passes = 5'd30; life = 12'd1000;
                red_a  = 1'b0;  blue_a = !sc_step[a];
            end
            2: begin
                passes = 5'd10; life = 12'd500;
                red_a  = sc_step[a]; blue_a = 1'b0;
            end
            3: begin
                passes = 5'd10; life = 12'd100;
                red_a  = !sc_step[a]; blue_a = 1'b0;
            end
            default: begin
                passes = 5'd20; life = 12'd500;
                red_a  = sc_step[a]; blue_a = !sc_step[a];
            end
        endcase
        sc_elapsed[a] = sc_elapsed[a] + ELAPSED_W'(TICK_MS);
        // action still alive: drive its levels
        if (sc_elapsed[a] < life) begin
            red_lit  = red_a;
            blue_lit = blue_a;
            return;
        end
        // lifetime reached: leds untouched, move to next action or pass
        nxt = {1'b0, sc_step[a]} + 2'd1;
        if (nxt < n_steps) begin
            sc_step[a] = nxt[0];
        end else begin
            sc_step[a] = 1'b0;
            sc_pass[a] = sc_pass[a] + 1'b1;
            if (sc_pass[a] >= passes) begin
                // scene over, hand over to the next winner keeping its position
                sc_running[a] = 1'b0;
                red_lit       = 1'b0;
                blue_lit      = 1'b0;
                now_playing   = best_scene();
                if (now_playing >= NO_SCENE) return;
                a = now_playing;
            end
        end
        sc_elapsed[a] = '0;
    endfunction

    function automatic void start_scene(logic [SCENE_W-1:0] id);
        logic [SCENE_W-1:0] win;
        if (id >= NO_SCENE || sc_running[id]) return;
        sc_running[id] = 1'b1;
        rewind(id);
        win = best_scene();
        // a preempted scene is stopped outright
        if (win != now_playing) begin
            if (now_playing < NO_SCENE) sc_running[now_playing] = 1'b0;
            now_playing = win;
        end
        // whoever is playing now starts over, even if unchanged
        if (now_playing < NO_SCENE) rewind(now_playing);
    endfunction

    function automatic void cancel_scene(logic [SCENE_W-1:0] id);
        if (id >= NO_SCENE) return;
        sc_running[id] = 1'b0;
        if (now_playing != id) return;
        red_lit     = 1'b0;
        blue_lit    = 1'b0;
        now_playing = best_scene();
        if (now_playing < NO_SCENE) rewind(now_playing);
    endfunction

    // apply one command and return the led state it leaves behind
    function automatic t_out_item step_sequencer(t_in_item it);
        t_out_item r;
        case (it.opcode)
            OP_TICK:   tick_active();
            OP_START:  start_scene(it.scene_id);
            OP_CANCEL: cancel_scene(it.scene_id);
            OP_DIRECT: begin
                if (it.led_select) blue_lit = it.led_level;
                else red_lit = it.led_level;
            end
            default: ;
        endcase
        r.red_on        = red_lit;
        r.blue_on       = blue_lit;
        r.playing_scene = now_playing;
        for (int s = 0; s < N_SCENES; s++) r.running_mask[s] = sc_running[s];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // command generation
    // ------------------------------------------------------------------

    function automatic t_in_item cmd(t_opcode op, int unsigned id, bit sel, bit lvl);
        t_in_item it;
        it.opcode     = op;
        it.scene_id   = SCENE_W'(id);
        it.led_select = sel;
        it.led_level  = lvl;
        return it;
    endfunction

    // mostly real scenes, now and then an out-of-range id
    function automatic int unsigned pick_id();
        if ($urandom_range(0, 9) == 0) return $urandom_range(5, 7);
        return $urandom_range(0, 4);
    endfunction

    // a burst of starts followed by a run of ticks, seasoned with direct sets and
    // stray starts or cancels; the occasional long run lets scenes finish and hand over
    task automatic queue_episode();
        int n_run;
        int roll;
        repeat ($urandom_range(1, 3))
            cmd_q.push_back(cmd(OP_START, pick_id(), $urandom_range(0, 1), $urandom_range(0, 1)));
        n_run = ($urandom_range(0, 5) == 0) ? $urandom_range(120, 220) : $urandom_range(5, 60);
        repeat (n_run) begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
                cmd_q.push_back(cmd(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 1),
                                    $urandom_range(0, 1)));
            else if (roll < 90)
                cmd_q.push_back(cmd(OP_DIRECT, $urandom_range(0, 7), $urandom_range(0, 1),
                                    $urandom_range(0, 1)));
            else if (roll < 96)
                cmd_q.push_back(cmd(OP_CANCEL, pick_id(), $urandom_range(0, 1),
                                    $urandom_range(0, 1)));
            else
                cmd_q.push_back(cmd(OP_START, pick_id(), $urandom_range(0, 1),
                                    $urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // sender: offers queued commands, drawing a gap after each transfer
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (in_xfer) send_gap = $urandom_range(0, send_gap_max);
        if (i_in_valid && !in_xfer) begin
            // still waiting for the transfer, payload held
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap--;
        end else if (cmd_q.size() != 0) begin
            i_in_item  <= cmd_q.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall after each transfer, plus one long hold-off
    // ------------------------------------------------------------------
    assign hold_active = pressure_go && (hold_cnt < HOLD_CYCLES);

    // the long hold-off counts its own cycles
    always @(posedge i_clk) begin
        if (hold_active) hold_cnt <= hold_cnt + 1;
    end

    always @(negedge i_clk) begin
        if (out_xfer) take_wait = $urandom_range(0, take_wait_max);
        i_out_stall <= hold_active || (take_wait > 0);
        if (take_wait > 0) take_wait--;
    end

    // ------------------------------------------------------------------
    // monitor: predicts on every input transfer, checks every output transfer
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : observe
        t_out_item want;
        in_xfer  = i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_xfer = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (out_xfer) begin
            if (pending_leds.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", o_out_item));
            end else begin
                want = pending_leds.pop_front();
                if (o_out_item.red_on !== want.red_on)
                    report_mismatch($sformatf("red_on got %b want %b",
                                              o_out_item.red_on, want.red_on));
                if (o_out_item.blue_on !== want.blue_on)
                    report_mismatch($sformatf("blue_on got %b want %b",
                                              o_out_item.blue_on, want.blue_on));
                if (o_out_item.playing_scene !== want.playing_scene)
                    report_mismatch($sformatf("playing_scene got %0d want %0d",
                                              o_out_item.playing_scene, want.playing_scene));
                if (o_out_item.running_mask !== want.running_mask)
                    report_mismatch($sformatf("running_mask got %b want %b",
                                              o_out_item.running_mask, want.running_mask));
            end
        end
        if (in_xfer) pending_leds.push_back(step_sequencer(i_in_item));
    end

    // watchdog: too long without any transfer means the block has hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** led_pattern_sequencer_with_priority: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // phase control
    // ------------------------------------------------------------------

    // only called with nothing in flight
    task automatic write_priorities(input logic [PRIOS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        prio_word      = v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every command has gone and every led state has come back
    task automatic drain();
        while (cmd_q.size() != 0 || i_in_valid || pending_leds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [PRIOS_W-1:0] setting;
        prio_word = PRIOS_RESET;
        for (int s = 0; s < N_SCENES; s++) begin
            sc_running[s] = 1'b0;
            rewind(s);
        end
        now_playing = NO_SCENE;
        red_lit     = 1'b0;
        blue_lit    = 1'b0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // phase 0 runs on the reset priorities (2,0,1,1,1); the rest cover all-zero and
            // all-seven (pure index ties), a reversed order, the reset priorities again and random
            if (ph != 0) begin
                case (ph)
                    1:       setting = '0;
                    2:       setting = '1;
                    3:       setting = 15'b000_001_010_011_100;
                    5:       setting = PRIOS_RESET;
                    default: setting = PRIOS_W'($urandom);
                endcase
                write_priorities(setting);
            end
            // every combination of idle and busy sides over the phases
            send_gap_max  = (ph % 2 != 0) ? 3 : 0;
            take_wait_max = ((ph / 2) % 2 != 0) ? 3 : 0;

            if (ph == 0) begin
                cmd_q.push_back(cmd(OP_TICK,   0, 1'b1, 1'b1)); // tick with nothing playing
                cmd_q.push_back(cmd(OP_DIRECT, 7, 1'b0, 1'b1)); // red on directly
                cmd_q.push_back(cmd(OP_DIRECT, 0, 1'b1, 1'b1)); // blue on directly
                cmd_q.push_back(cmd(OP_DIRECT, 5, 1'b0, 1'b0));
                cmd_q.push_back(cmd(OP_DIRECT, 2, 1'b1, 1'b0));
                cmd_q.push_back(cmd(OP_START,  7, 1'b1, 1'b0)); // out-of-range ids ignored
                cmd_q.push_back(cmd(OP_START,  5, 1'b0, 1'b1));
                cmd_q.push_back(cmd(OP_CANCEL, 6, 1'b1, 1'b1));
                cmd_q.push_back(cmd(OP_START,  3, 1'b0, 1'b0)); // first scene takes over
                cmd_q.push_back(cmd(OP_TICK,   4, 1'b0, 1'b0));
                cmd_q.push_back(cmd(OP_TICK,   1, 1'b1, 1'b0)); // lifetime reached, leds kept
                cmd_q.push_back(cmd(OP_TICK,   3, 1'b0, 1'b1));
                cmd_q.push_back(cmd(OP_START,  3, 1'b1, 1'b1)); // already running
                cmd_q.push_back(cmd(OP_START,  0, 1'b0, 1'b0)); // loses, active one restarts
                cmd_q.push_back(cmd(OP_START,  2, 1'b1, 1'b0)); // tie, lower index preempts
                cmd_q.push_back(cmd(OP_CANCEL, 0, 1'b0, 1'b1)); // cancel of a waiting scene
                cmd_q.push_back(cmd(OP_TICK,   6, 1'b1, 1'b1));
                cmd_q.push_back(cmd(OP_DIRECT, 3, 1'b1, 1'b1));
                cmd_q.push_back(cmd(OP_START,  1, 1'b0, 1'b0)); // top priority preempts
                cmd_q.push_back(cmd(OP_TICK,   2, 1'b0, 1'b1));
                cmd_q.push_back(cmd(OP_CANCEL, 1, 1'b1, 1'b0)); // cancel of the playing scene
                cmd_q.push_back(cmd(OP_TICK,   5, 1'b1, 1'b0));
                cmd_q.push_back(cmd(OP_START,  4, 1'b0, 1'b1));
                cmd_q.push_back(cmd(OP_CANCEL, 7, 1'b0, 1'b0));
                cmd_q.push_back(cmd(OP_DIRECT, 4, 1'b0, 1'b1));
            end

            while (cmd_q.size() < PHASE_ITEMS) queue_episode();

            // receiver holds off while the sender keeps offering, so the block fills
            if (ph == 2) pressure_go = 1'b1;

            drain();
        end

        if (mismatches == 0)
            $display("** led_pattern_sequencer_with_priority: PASSED **");
        else
            $display("** led_pattern_sequencer_with_priority: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lps_pkg.sv
design/lps_pick.sv
design/lps_core.sv
design/led_pattern_sequencer_with_priority.sv
bench/led_pattern_sequencer_with_priority_tb.sv
